// ===== hdl/dta_pkg.sv =====
// dta_pkg: field widths, op and status codes, controller/datapath command and status types
// and the address width helper for the delayed template overlap-add block
// no dependencies
`timescale 1ns / 1ps

package dta_pkg;

  localparam int unsigned DEF_NUM_TEMPLATES = 4;
  localparam int unsigned DEF_TEMPLATE_LEN  = 16;
  localparam int unsigned DEF_NUM_DIMS      = 4;
  localparam int unsigned DEF_MAX_TRAJ_LEN  = 256;
  localparam int unsigned DEF_TRAJ_LEN      = 256;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned TIDX_W   = 2;
  localparam int unsigned TSTEP_W  = 4;
  localparam int unsigned DIM_W    = 2;
  localparam int unsigned TIME_W   = 8;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned AMP_W    = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 9;

  // width for address arithmetic before truncation to a memory address
  localparam int unsigned CALC_W = 17;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_ACT   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  function automatic int unsigned addr_w(input int unsigned depth);
    int unsigned w;
    w = (depth > 1) ? $clog2(depth) : 1;
    return w;
  endfunction

  typedef struct packed {
    logic capture;
    logic sweep;
    logic sweep_store;
    logic load_wr;
    logic mac_issue;
    logic rd_issue;
    logic done;
  } dta_cmd_t;

  typedef struct packed {
    logic init_last;
    logic clr_last;
    logic elem_last;
    logic tidx_bad;
  } dta_sts_t;

endpackage

// ===== hdl/dta_ram.sv =====
// dta_ram: generic single write port, single read port RAM with registered read
// depends on dta_pkg for the address width helper
`timescale 1ns / 1ps

module dta_ram
  import dta_pkg::*;
#(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [addr_w(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [addr_w(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dta_ctrl.sv =====
// dta_ctrl: request sequencer for the overlap-add block (init sweep, load,
// clear sweep, activation walk with drain, read); depends on dta_pkg
`timescale 1ns / 1ps

module dta_ctrl
  import dta_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic [OP_W-1:0] op_i,
  input  dta_sts_t        sts_i,
  output dta_cmd_t        cmd_o,
  output logic            busy
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_MAC    = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_RDWAIT = 3'd7;

  // multiply-accumulate pipeline depth after the last issue
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] drain_q, drain_d;
  dta_cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    cmd     = '0;
    case (state_q)
      S_INIT: begin
        cmd.sweep       = 1'b1;
        cmd.sweep_store = 1'b1;
        if (sts_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (op_i)
            OP_LOAD:  state_d = S_LOAD;
            OP_CLEAR: state_d = S_CLEAR;
            OP_ACT:   state_d = S_MAC;
            OP_READ:  state_d = S_READ;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        cmd.done    = 1'b1;
        state_d     = S_IDLE;
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts_i.clr_last) begin
          cmd.done = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_MAC: begin
        if (sts_i.tidx_bad) begin
          cmd.done = 1'b1;
          state_d  = S_IDLE;
        end else begin
          cmd.mac_issue = 1'b1;
          if (sts_i.elem_last) begin
            drain_d = '0;
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (drain_q == DRAIN_LAST) begin
          cmd.done = 1'b1;
          state_d  = S_IDLE;
        end else begin
          drain_d = drain_q + 2'd1;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_d      = S_RDWAIT;
      end
      S_RDWAIT: begin
        cmd.done = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
    end
  end

  assign cmd_o = cmd;
  assign busy  = (state_q != S_IDLE);

endmodule

// ===== hdl/dta_dp.sv =====
// dta_dp: datapath with template store, trajectory accumulator, address counters,
// multiply / saturating add pipeline and result registers; depends on dta_pkg, dta_ram
`timescale 1ns / 1ps

module dta_dp
  import dta_pkg::*;
#(
  parameter int unsigned NUM_TEMPLATES = DEF_NUM_TEMPLATES,
  parameter int unsigned TEMPLATE_LEN  = DEF_TEMPLATE_LEN,
  parameter int unsigned NUM_DIMS      = DEF_NUM_DIMS,
  parameter int unsigned MAX_TRAJ_LEN  = DEF_MAX_TRAJ_LEN
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dta_cmd_t                   cmd_i,
  output dta_sts_t                   sts_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic [TIDX_W-1:0]          template_index_i,
  input  logic [TSTEP_W-1:0]         template_step_i,
  input  logic [DIM_W-1:0]           dimension_i,
  input  logic [TIME_W-1:0]          time_index_i,
  input  logic signed [WEIGHT_W-1:0] weight_i,
  input  logic signed [AMP_W-1:0]    amplitude_i,
  input  logic [OP_W-1:0]            op_i,
  output logic signed [VALUE_W-1:0]  read_value_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic                       saturated_o,
  output logic                       result_valid_o
);

  localparam int unsigned STORE_DEPTH = NUM_TEMPLATES * TEMPLATE_LEN * NUM_DIMS;
  localparam int unsigned ACC_DEPTH   = MAX_TRAJ_LEN * NUM_DIMS;
  localparam int unsigned INIT_DEPTH  = (STORE_DEPTH > ACC_DEPTH) ? STORE_DEPTH : ACC_DEPTH;
  localparam int unsigned ST_AW       = addr_w(STORE_DEPTH);
  localparam int unsigned ACC_AW      = addr_w(ACC_DEPTH);
  localparam int unsigned SW          = addr_w(INIT_DEPTH);
  localparam int unsigned KW          = addr_w(TEMPLATE_LEN);
  localparam int unsigned DW          = addr_w(NUM_DIMS);
  localparam int unsigned LEN_W       = $clog2(MAX_TRAJ_LEN + 1);
  localparam int unsigned CMP_W       = ((LEN_W > TIME_W + 1) ? LEN_W : TIME_W + 1) + 1;
  localparam int unsigned RST_LEN     = (MAX_TRAJ_LEN < DEF_TRAJ_LEN) ? MAX_TRAJ_LEN
                                                                      : DEF_TRAJ_LEN;

  // captured request
  logic [OP_W-1:0]            op_q;
  logic [TIDX_W-1:0]          tidx_q;
  logic [TSTEP_W-1:0]         tstep_q;
  logic [DIM_W-1:0]           dim_q;
  logic [TIME_W-1:0]          tix_q;
  logic signed [WEIGHT_W-1:0] weight_q;
  logic signed [AMP_W-1:0]    amp_q;

  logic [CMP_W-1:0] eff_len_q, eff_len_d, cfg_ext;
  logic [SW-1:0]    cnt_q;
  logic [KW-1:0]    k_q;
  logic [DW-1:0]    d_q;

  logic init_last, clr_last, sweep_wrap, k_last, d_last;
  logic tidx_bad, load_ok, rd_ok, overrun, in_len;
  logic [CMP_W-1:0] t_cur, t_end;

  logic [CALC_W-1:0] st_rd_calc, st_ld_calc, acc_mac_calc, acc_rd_calc;

  logic                      s1_vld_q, s2_vld_q;
  logic [ACC_AW-1:0]         s1_addr_q, s2_addr_q;
  logic signed [VALUE_W-1:0] prod_q;
  logic [VALUE_W-1:0]        acc_q;
  logic [VALUE_W:0]          sum;
  logic [VALUE_W-1:0]        sum_sat;
  logic                      ovf;
  logic                      sat_q;

  logic                    st_we, acc_we, sweep_st, sweep_acc;
  logic [ST_AW-1:0]        st_waddr, st_raddr;
  logic [WEIGHT_W-1:0]     st_wdata, st_rdata;
  logic [ACC_AW-1:0]       acc_waddr, acc_raddr;
  logic [VALUE_W-1:0]      acc_wdata, acc_rdata;

  logic                      res_vld_q;
  logic [VALUE_W-1:0]        res_value_q, res_value_d;
  logic [STATUS_W-1:0]       res_status_q, res_status_d;
  logic                      res_sat_q, res_sat_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= op_i;
      tidx_q   <= template_index_i;
      tstep_q  <= template_step_i;
      dim_q    <= dimension_i;
      tix_q    <= time_index_i;
      weight_q <= weight_i;
      amp_q    <= amplitude_i;
    end
  end

  // length register, clamped to 1..MAX_TRAJ_LEN on write
  assign cfg_ext = CMP_W'(cfg_data_i);

  always_comb begin
    eff_len_d = cfg_ext;
    if (cfg_ext == '0) begin
      eff_len_d = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_TRAJ_LEN)) begin
      eff_len_d = CMP_W'(MAX_TRAJ_LEN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_len_q <= CMP_W'(RST_LEN);
    end else if (cfg_we_i) begin
      eff_len_q <= eff_len_d;
    end
  end

  // sweep counter for init and clear
  assign init_last  = (cnt_q == SW'(INIT_DEPTH - 1));
  assign clr_last   = (cnt_q == SW'(ACC_DEPTH - 1));
  assign sweep_wrap = cmd_i.sweep_store ? init_last : clr_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      cnt_q <= sweep_wrap ? '0 : cnt_q + SW'(1);
    end
  end

  // template step / dimension walk
  assign k_last = (k_q == KW'(TEMPLATE_LEN - 1));
  assign d_last = (d_q == DW'(NUM_DIMS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      d_q <= '0;
    end else if (cmd_i.capture) begin
      k_q <= '0;
      d_q <= '0;
    end else if (cmd_i.mac_issue) begin
      if (d_last) begin
        d_q <= '0;
        k_q <= k_q + KW'(1);
      end else begin
        d_q <= d_q + DW'(1);
      end
    end
  end

  // range checks
  assign tidx_bad = (32'(tidx_q) >= 32'(NUM_TEMPLATES));
  assign load_ok  = !tidx_bad && (32'(tstep_q) < 32'(TEMPLATE_LEN))
                    && (32'(dim_q) < 32'(NUM_DIMS));
  assign rd_ok    = (CMP_W'(tix_q) < eff_len_q) && (32'(dim_q) < 32'(NUM_DIMS));
  assign t_cur    = CMP_W'(tix_q) + CMP_W'(k_q);
  assign t_end    = CMP_W'(tix_q) + CMP_W'(TEMPLATE_LEN - 1);
  assign in_len   = (t_cur < eff_len_q);
  assign overrun  = (t_end >= eff_len_q);

  // addresses
  assign st_rd_calc   = (CALC_W'(tidx_q) * CALC_W'(TEMPLATE_LEN) + CALC_W'(k_q))
                        * CALC_W'(NUM_DIMS) + CALC_W'(d_q);
  assign st_ld_calc   = (CALC_W'(tidx_q) * CALC_W'(TEMPLATE_LEN) + CALC_W'(tstep_q))
                        * CALC_W'(NUM_DIMS) + CALC_W'(dim_q);
  assign acc_mac_calc = CALC_W'(t_cur) * CALC_W'(NUM_DIMS) + CALC_W'(d_q);
  assign acc_rd_calc  = CALC_W'(tix_q) * CALC_W'(NUM_DIMS) + CALC_W'(dim_q);

  // multiply-accumulate pipeline: issue, multiply, saturating add and write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      sat_q    <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.mac_issue && in_len;
      s2_vld_q <= s1_vld_q;
      if (cmd_i.capture) begin
        sat_q <= 1'b0;
      end else if (s2_vld_q && ovf) begin
        sat_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= acc_mac_calc[ACC_AW-1:0];
    s2_addr_q <= s1_addr_q;
    prod_q    <= VALUE_W'($signed(st_rdata)) * VALUE_W'(amp_q);
    acc_q     <= acc_rdata;
  end

  assign sum = {acc_q[VALUE_W-1], acc_q} + {prod_q[VALUE_W-1], prod_q};
  assign ovf = (sum[VALUE_W] != sum[VALUE_W-1]);

  always_comb begin
    sum_sat = sum[VALUE_W-1:0];
    if (ovf) begin
      sum_sat = sum[VALUE_W] ? VALUE_MIN : VALUE_MAX;
    end
  end

  // memory ports
  assign sweep_st  = cmd_i.sweep && cmd_i.sweep_store
                     && ({1'b0, cnt_q} < (SW + 1)'(STORE_DEPTH));
  assign sweep_acc = cmd_i.sweep && ({1'b0, cnt_q} < (SW + 1)'(ACC_DEPTH));

  assign st_we    = sweep_st || (cmd_i.load_wr && load_ok);
  assign st_waddr = cmd_i.sweep ? cnt_q[ST_AW-1:0] : st_ld_calc[ST_AW-1:0];
  assign st_wdata = cmd_i.sweep ? '0 : weight_q;
  assign st_raddr = st_rd_calc[ST_AW-1:0];

  assign acc_we    = sweep_acc || s2_vld_q;
  assign acc_waddr = cmd_i.sweep ? cnt_q[ACC_AW-1:0] : s2_addr_q;
  assign acc_wdata = cmd_i.sweep ? '0 : sum_sat;
  assign acc_raddr = cmd_i.rd_issue ? acc_rd_calc[ACC_AW-1:0] : acc_mac_calc[ACC_AW-1:0];

  dta_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  dta_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (ACC_DEPTH)
  ) u_acc (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // result formatting
  always_comb begin
    res_value_d  = '0;
    res_status_d = ST_OK;
    res_sat_d    = 1'b0;
    case (op_q)
      OP_LOAD: begin
        res_status_d = load_ok ? ST_OK : ST_RANGE;
      end
      OP_ACT: begin
        if (tidx_bad) begin
          res_status_d = ST_RANGE;
        end else begin
          res_status_d = overrun ? ST_OVERRUN : ST_OK;
          res_sat_d    = sat_q;
        end
      end
      OP_READ: begin
        if (rd_ok) begin
          res_value_d = acc_rdata;
        end else begin
          res_status_d = ST_RANGE;
        end
      end
      default: begin
        res_status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
      res_sat_q    <= res_sat_d;
    end
  end

  assign sts_o.init_last = init_last;
  assign sts_o.clr_last  = clr_last;
  assign sts_o.elem_last = k_last && d_last;
  assign sts_o.tidx_bad  = tidx_bad;

  assign read_value_o   = $signed(res_value_q);
  assign status_o       = res_status_q;
  assign saturated_o    = res_sat_q;
  assign result_valid_o = res_vld_q;

endmodule

// ===== hdl/delayed_template_overlap_add.sv =====
// delayed_template_overlap_add: top level, controller plus datapath; depends on dta_pkg,
// dta_ctrl and dta_dp; a clear sweeps every accumulator entry
// activation: one accumulator read-modify-write per cycle, then a drain of the pipeline
// busy is held after reset while the init sweep zeroes both the store and the accumulator
// results are single-cycle strobes; the receiver cannot stall, one request in flight at a time
`timescale 1ns / 1ps

module delayed_template_overlap_add
  import dta_pkg::*;
#(
  parameter int unsigned NUM_TEMPLATES = DEF_NUM_TEMPLATES,
  parameter int unsigned TEMPLATE_LEN  = DEF_TEMPLATE_LEN,
  parameter int unsigned NUM_DIMS      = DEF_NUM_DIMS,
  parameter int unsigned MAX_TRAJ_LEN  = DEF_MAX_TRAJ_LEN
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_we_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic [OP_W-1:0]            op_i,
  input  logic [TIDX_W-1:0]          template_index_i,
  input  logic [TSTEP_W-1:0]         template_step_i,
  input  logic [DIM_W-1:0]           dimension_i,
  input  logic [TIME_W-1:0]          time_index_i,
  input  logic signed [WEIGHT_W-1:0] weight_i,
  input  logic signed [AMP_W-1:0]    amplitude_i,
  output logic signed [VALUE_W-1:0]  read_value_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic                       saturated_o,
  output logic                       result_valid_o
);

  dta_cmd_t cmd;
  dta_sts_t sts;

  dta_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  dta_dp #(
    .NUM_TEMPLATES (NUM_TEMPLATES),
    .TEMPLATE_LEN  (TEMPLATE_LEN),
    .NUM_DIMS      (NUM_DIMS),
    .MAX_TRAJ_LEN  (MAX_TRAJ_LEN)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .template_index_i (template_index_i),
    .template_step_i  (template_step_i),
    .dimension_i      (dimension_i),
    .time_index_i     (time_index_i),
    .weight_i         (weight_i),
    .amplitude_i      (amplitude_i),
    .op_i             (op_i),
    .read_value_o     (read_value_o),
    .status_o         (status_o),
    .saturated_o      (saturated_o),
    .result_valid_o   (result_valid_o)
  );

endmodule

// ===== tb/sv/delayed_template_overlap_add_test.sv =====
// delayed_template_overlap_add_test: self-checking bench for the overlap-add block,
// a predictor of the template store and trajectory accumulator checks every result
// depends on dta_pkg and delayed_template_overlap_add
`timescale 1ns / 1ps

module delayed_template_overlap_add_test;
  import dta_pkg::*;

  localparam int unsigned PHASE_ITEMS = 204;
  localparam int unsigned NUM_PHASES  = 8;

  typedef struct {
    logic [OP_W-1:0]            op;
    logic [TIDX_W-1:0]          tidx;
    logic [TSTEP_W-1:0]         tstep;
    logic [DIM_W-1:0]           dim;
    logic [TIME_W-1:0]          tix;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [AMP_W-1:0]    amp;
  } request_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic                      sat;
  } outcome_t;

  class traj_scoreboard;
    logic signed [WEIGHT_W-1:0] tmpl_mem [DEF_NUM_TEMPLATES][DEF_TEMPLATE_LEN][DEF_NUM_DIMS];
    logic signed [VALUE_W-1:0]  traj_mem [DEF_MAX_TRAJ_LEN][DEF_NUM_DIMS];
    logic [CFG_W-1:0]           traj_len;
    outcome_t                   pending [$];
    int unsigned                errors;

    function new();
      foreach (tmpl_mem[i, j, k]) tmpl_mem[i][j][k] = '0;
      clear_traj();
      traj_len = CFG_W'(DEF_TRAJ_LEN);
      errors   = 0;
    endfunction

    function void clear_traj();
      foreach (traj_mem[i, j]) traj_mem[i][j] = '0;
    endfunction

    function void set_length(logic [CFG_W-1:0] v);
      traj_len = v;
    endfunction

    function int unsigned eff_length();
      if (traj_len < 1) return 1;
      if (traj_len > DEF_MAX_TRAJ_LEN) return DEF_MAX_TRAJ_LEN;
      return traj_len;
    endfunction

    function bit drained();
      return pending.size() == 0;
    endfunction

    function void note_request(request_t r);
      outcome_t    o;
      int unsigned len;
      int unsigned t;
      longint      sum;
      o   = '{value: '0, status: ST_OK, sat: 1'b0};
      len = eff_length();
      case (r.op)
        OP_LOAD: begin
          if (r.tidx < DEF_NUM_TEMPLATES && r.tstep < DEF_TEMPLATE_LEN && r.dim < DEF_NUM_DIMS)
            tmpl_mem[r.tidx][r.tstep][r.dim] = r.weight;
          else
            o.status = ST_RANGE;
        end
        OP_CLEAR: clear_traj();
        OP_ACT: begin
          if (r.tidx >= DEF_NUM_TEMPLATES) begin
            o.status = ST_RANGE;
          end else begin
            for (int k = 0; k < DEF_TEMPLATE_LEN; k++) begin
              t = r.tix + k;
              if (t >= len) begin
                o.status = ST_OVERRUN;
              end else begin
                for (int d = 0; d < DEF_NUM_DIMS; d++) begin
                  sum = longint'(traj_mem[t][d])
                        + longint'(tmpl_mem[r.tidx][k][d]) * longint'(r.amp);
                  if (sum > 64'sd2147483647) begin
                    traj_mem[t][d] = VALUE_MAX;
                    o.sat = 1'b1;
                  end else if (sum < -64'sd2147483648) begin
                    traj_mem[t][d] = VALUE_MIN;
                    o.sat = 1'b1;
                  end else begin
                    traj_mem[t][d] = VALUE_W'(sum);
                  end
                end
              end
            end
          end
        end
        default: begin
          if (r.tix < len && r.dim < DEF_NUM_DIMS)
            o.value = traj_mem[r.tix][r.dim];
          else
            o.status = ST_RANGE;
        end
      endcase
      pending.push_back(o);
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] value, logic [STATUS_W-1:0] status,
                               logic sat);
      outcome_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: read_value %0d status %0d saturated %0d",
               value, status, sat);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (value !== e.value) begin
        $error("read_value: expected %0d, got %0d", e.value, value);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated: expected %0d, got %0d", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_W-1:0]           cfg_data_i = '0;
  logic [OP_W-1:0]            op_i = '0;
  logic [TIDX_W-1:0]          template_index_i = '0;
  logic [TSTEP_W-1:0]         template_step_i = '0;
  logic [DIM_W-1:0]           dimension_i = '0;
  logic [TIME_W-1:0]          time_index_i = '0;
  logic signed [WEIGHT_W-1:0] weight_i = '0;
  logic signed [AMP_W-1:0]    amplitude_i = '0;
  logic signed [VALUE_W-1:0]  read_value_o;
  logic [STATUS_W-1:0]        status_o;
  logic                       saturated_o;
  logic                       result_valid_o;

  traj_scoreboard sb = new();

  delayed_template_overlap_add DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .template_index_i (template_index_i),
    .template_step_i  (template_step_i),
    .dimension_i      (dimension_i),
    .time_index_i     (time_index_i),
    .weight_i         (weight_i),
    .amplitude_i      (amplitude_i),
    .read_value_o     (read_value_o),
    .status_o         (status_o),
    .saturated_o      (saturated_o),
    .result_valid_o   (result_valid_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(read_value_o, status_o, saturated_o);
  end

  function automatic request_t make_request(logic [OP_W-1:0] op, int tidx, int tstep, int dim,
                                            int tix, int weight, int amp);
    request_t r;
    r.op     = op;
    r.tidx   = TIDX_W'(tidx);
    r.tstep  = TSTEP_W'(tstep);
    r.dim    = DIM_W'(dim);
    r.tix    = TIME_W'(tix);
    r.weight = WEIGHT_W'(weight);
    r.amp    = AMP_W'(amp);
    return r;
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_amplitude();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'h8000;
    if (sel == 1) return 16'h7FFF;
    if (sel < 6) return 16'(int'($urandom_range(0, 1024)) - 512);
    return 16'($urandom);
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned len;
    int unsigned sel;
    int unsigned lo;
    int unsigned hi;
    len      = sb.eff_length();
    r.tidx   = TIDX_W'($urandom);
    r.tstep  = TSTEP_W'($urandom);
    r.dim    = DIM_W'($urandom);
    r.tix    = TIME_W'($urandom);
    r.weight = pick_weight();
    r.amp    = pick_amplitude();
    sel      = $urandom_range(0, 99);
    if (sel < 2) begin
      r.op = OP_CLEAR;
    end else if (sel < 35) begin
      r.op = OP_LOAD;
    end else if (sel < 67) begin
      r.op = OP_ACT;
      case ($urandom_range(0, 3))
        0: ;
        3: begin
          lo    = (len > 16) ? len - 16 : 0;
          hi    = (len + 2 > 255) ? 255 : len + 2;
          r.tix = TIME_W'($urandom_range(lo, hi));
        end
        default: r.tix = TIME_W'($urandom_range(0, len - 1));
      endcase
    end else begin
      r.op = OP_READ;
      if ($urandom_range(0, 4) != 0) r.tix = TIME_W'($urandom_range(0, len - 1));
    end
    return r;
  endfunction

  // called and returns at a falling edge
  task automatic send_request(input request_t r);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start            <= 1'b1;
    op_i             <= r.op;
    template_index_i <= r.tidx;
    template_step_i  <= r.tstep;
    dimension_i      <= r.dim;
    time_index_i     <= r.tix;
    weight_i         <= r.weight;
    amplitude_i      <= r.amp;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (!sb.drained()) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    sb.set_length(v);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    request_t         directed [$];
    logic [CFG_W-1:0] phase_len [NUM_PHASES];

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes of the store, positive and negative saturation, runs past the end
    directed.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(OP_LOAD, 3, 15, 3, 0, -32768, 0));
    directed.push_back(make_request(OP_LOAD, 0, 0, 0, 255, 32767, 0));
    directed.push_back(make_request(OP_LOAD, 3, 0, 0, 0, 32767, 0));
    directed.push_back(make_request(OP_ACT, 3, 0, 0, 0, 0, -32768));
    directed.push_back(make_request(OP_ACT, 3, 0, 0, 0, 0, -32768));
    directed.push_back(make_request(OP_READ, 0, 0, 3, 15, 0, 0));
    directed.push_back(make_request(OP_ACT, 0, 0, 0, 240, 0, 32767));
    directed.push_back(make_request(OP_ACT, 0, 0, 0, 241, 0, 1));
    directed.push_back(make_request(OP_ACT, 2, 0, 0, 255, 0, 1));
    directed.push_back(make_request(OP_READ, 0, 0, 3, 255, 0, 0));
    directed.push_back(make_request(OP_READ, 0, 0, 0, 240, 0, 0));
    directed.push_back(make_request(OP_CLEAR, 3, 15, 3, 255, -1, -1));
    directed.push_back(make_request(OP_READ, 0, 0, 3, 15, 0, 0));
    directed.push_back(make_request(OP_ACT, 3, 0, 0, 0, 0, 32767));
    directed.push_back(make_request(OP_ACT, 3, 0, 0, 0, 0, 32767));
    directed.push_back(make_request(OP_ACT, 3, 0, 0, 0, 0, 32767));
    directed.push_back(make_request(OP_READ, 0, 0, 3, 15, 0, 0));
    directed.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(OP_ACT, 1, 0, 0, 10, 0, 0));
    directed.push_back(make_request(OP_LOAD, 2, 7, 1, 0, -1, 0));
    directed.push_back(make_request(OP_ACT, 2, 0, 0, 200, 0, -1));
    directed.push_back(make_request(OP_READ, 0, 0, 1, 207, 0, 0));
    foreach (directed[i]) send_request(directed[i]);

    phase_len = '{9'd1, 9'd0, 9'd511, 9'd16, 9'd255, 9'($urandom_range(2, 255)),
                  9'd256, 9'($urandom_range(257, 511))};
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_length(phase_len[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // let the block run dry partway through
        if (i == PHASE_ITEMS / 2) wait_drained();
        send_request(random_request());
      end
    end

    wait_drained();
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.drained()) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
